// File: hdl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under active-low reset.
`define CHK_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under active-low reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/gtoe_pkg.sv
// Types, codes and microcode layout of the topological order engine.
`default_nettype none

package gtoe_pkg;

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_DECLARE = 2'd1;
	localparam logic [1:0] OP_EDGE    = 2'd2;
	localparam logic [1:0] OP_RUN     = 2'd3;

	localparam logic [1:0] KIND_INPUT  = 2'd0;
	localparam logic [1:0] KIND_SHADER = 2'd1;
	localparam logic [1:0] KIND_BUFFER = 2'd2;
	localparam logic [1:0] KIND_OUTPUT = 2'd3;

	localparam logic [1:0] ST_ORDERED = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_CYCLE   = 2'd2;
	localparam logic [1:0] ST_REJECT  = 2'd3;

	typedef logic [4:0] upc_t;

	localparam upc_t UPC_IDLE  = 5'd0;
	localparam upc_t UPC_EDGE0 = 5'd1;
	localparam upc_t UPC_EDGE1 = 5'd2;
	localparam upc_t UPC_EDGE2 = 5'd3;
	localparam upc_t UPC_EDGE3 = 5'd4;
	localparam upc_t UPC_RUN0  = 5'd5;
	localparam upc_t UPC_INIT0 = 5'd6;
	localparam upc_t UPC_INIT1 = 5'd7;
	localparam upc_t UPC_INIT2 = 5'd8;
	localparam upc_t UPC_POP   = 5'd9;
	localparam upc_t UPC_NODE  = 5'd10;
	localparam upc_t UPC_VISIT = 5'd11;
	localparam upc_t UPC_ECHK  = 5'd12;
	localparam upc_t UPC_TGT   = 5'd13;
	localparam upc_t UPC_RELAX = 5'd14;
	localparam upc_t UPC_END   = 5'd15;
	localparam upc_t UPC_CHECK = 5'd16;
	localparam upc_t UPC_RUNB  = 5'd17;
	localparam upc_t UPC_DONE  = 5'd18;

	typedef enum logic [4:0] {
		ACT_NONE,
		ACT_ACCEPT,
		ACT_RD_SRC,
		ACT_RD_DST,
		ACT_EDGE_SRC,
		ACT_EDGE_DST,
		ACT_PASS_A,
		ACT_PASS_B,
		ACT_INIT,
		ACT_RD_SEED,
		ACT_SEED,
		ACT_POP,
		ACT_RD_NODE,
		ACT_VISIT,
		ACT_RD_EDGE,
		ACT_RD_WORK,
		ACT_RELAX
	} act_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_NODE,
		EM_REJECT,
		EM_CYCLE,
		EM_DONE
	} emit_t;

	typedef enum logic [3:0] {
		CND_NEXT,
		CND_ALWAYS,
		CND_DISPATCH,
		CND_REJECT,
		CND_MORE_NODES,
		CND_SP_ZERO,
		CND_K_DONE,
		CND_PASS_B,
		CND_MISMATCH
	} cond_t;

	typedef struct packed {
		act_t  act;
		emit_t emit;
		cond_t cond;
		upc_t  target;
	} ctrl_t;

	typedef struct packed {
		logic hold;
		logic op_edge;
		logic op_run;
		logic reject;
		logic more_nodes;
		logic sp_zero;
		logic k_done;
		logic pass_b;
		logic mismatch;
	} stat_t;

endpackage

`default_nettype wire

// File: hdl/gtoe_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none

module gtoe_seq import gtoe_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	upc_t upc_q;
	upc_t jump_pc;
	logic taken;

	function automatic ctrl_t rom(input upc_t pc);
		ctrl_t w;
		unique case (pc)
			UPC_IDLE:  w = '{ACT_ACCEPT,   EM_NONE,   CND_DISPATCH,   UPC_EDGE0};
			UPC_EDGE0: w = '{ACT_RD_SRC,   EM_NONE,   CND_NEXT,       UPC_IDLE};
			UPC_EDGE1: w = '{ACT_RD_DST,   EM_NONE,   CND_NEXT,       UPC_IDLE};
			UPC_EDGE2: w = '{ACT_EDGE_SRC, EM_REJECT, CND_REJECT,     UPC_IDLE};
			UPC_EDGE3: w = '{ACT_EDGE_DST, EM_NONE,   CND_ALWAYS,     UPC_IDLE};
			UPC_RUN0:  w = '{ACT_PASS_A,   EM_NONE,   CND_NEXT,       UPC_IDLE};
			UPC_INIT0: w = '{ACT_INIT,     EM_NONE,   CND_NEXT,       UPC_IDLE};
			UPC_INIT1: w = '{ACT_RD_SEED,  EM_NONE,   CND_NEXT,       UPC_IDLE};
			UPC_INIT2: w = '{ACT_SEED,     EM_NONE,   CND_MORE_NODES, UPC_INIT1};
			UPC_POP:   w = '{ACT_POP,      EM_NONE,   CND_SP_ZERO,    UPC_END};
			UPC_NODE:  w = '{ACT_RD_NODE,  EM_NONE,   CND_NEXT,       UPC_IDLE};
			UPC_VISIT: w = '{ACT_VISIT,    EM_NODE,   CND_NEXT,       UPC_IDLE};
			UPC_ECHK:  w = '{ACT_RD_EDGE,  EM_NONE,   CND_K_DONE,     UPC_POP};
			UPC_TGT:   w = '{ACT_RD_WORK,  EM_NONE,   CND_NEXT,       UPC_IDLE};
			UPC_RELAX: w = '{ACT_RELAX,    EM_NONE,   CND_ALWAYS,     UPC_ECHK};
			UPC_END:   w = '{ACT_NONE,     EM_CYCLE,  CND_PASS_B,     UPC_DONE};
			UPC_CHECK: w = '{ACT_NONE,     EM_NONE,   CND_MISMATCH,   UPC_IDLE};
			UPC_RUNB:  w = '{ACT_PASS_B,   EM_NONE,   CND_ALWAYS,     UPC_INIT0};
			UPC_DONE:  w = '{ACT_NONE,     EM_DONE,   CND_ALWAYS,     UPC_IDLE};
			default:   w = '{ACT_NONE,     EM_NONE,   CND_ALWAYS,     UPC_IDLE};
		endcase
		return w;
	endfunction

	assign ctrl = rom(upc_q);

	always_comb begin
		jump_pc = ctrl.target;
		unique case (ctrl.cond)
			CND_NEXT:       taken = 1'b0;
			CND_ALWAYS:     taken = 1'b1;
			CND_DISPATCH: begin
				taken = 1'b1;
				priority if (stat.op_run) begin
					jump_pc = UPC_RUN0;
				end else if (!stat.op_edge) begin
					jump_pc = UPC_IDLE;
				end
			end
			CND_REJECT:     taken = stat.reject;
			CND_MORE_NODES: taken = stat.more_nodes;
			CND_SP_ZERO:    taken = stat.sp_zero;
			CND_K_DONE:     taken = stat.k_done;
			CND_PASS_B:     taken = stat.pass_b;
			CND_MISMATCH:   taken = stat.mismatch;
			default:        taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else if (!stat.hold) begin
			upc_q <= taken ? jump_pc : upc_q + upc_t'(1);
		end
	end

endmodule

`default_nettype wire

// File: hdl/gtoe_dp.sv
// Datapath: node table, edge store, work degrees, stack and result register.
`default_nettype none

module gtoe_dp import gtoe_pkg::*; #(
	parameter int MAX_NODES  = 32,
	parameter int EDGE_SLOTS = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	output logic       item_ready,
	input  wire  [1:0] opcode,
	input  wire  [4:0] node_slot,
	input  wire  [1:0] node_kind,
	input  wire  [4:0] edge_source,
	input  wire  [4:0] edge_target,
	output logic       result_valid,
	input  wire        result_ready,
	output logic [4:0] node_index,
	output logic [1:0] status,
	output logic       last,
	input  ctrl_t      ctrl,
	output stat_t      stat
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int DW = $clog2(EDGE_SLOTS + 1);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int EW = $clog2(MAX_NODES * EDGE_SLOTS);

	logic [DW-1:0] in_mem    [MAX_NODES];
	logic [DW-1:0] out_mem   [MAX_NODES];
	logic [1:0]    kind_mem  [MAX_NODES];
	logic [DW-1:0] work_mem  [MAX_NODES];
	logic [NW-1:0] stack_mem [MAX_NODES];
	logic [NW-1:0] edge_mem  [MAX_NODES * EDGE_SLOTS];

	logic [MAX_NODES-1:0] used_q;
	logic [MAX_NODES-1:0] in_vld_q;
	logic [MAX_NODES-1:0] out_vld_q;
	logic [CW-1:0]        sp_q;
	logic [CW-1:0]        ucnt_q;
	logic [CW-1:0]        vis_q;
	logic                 pass_q;
	logic                 out_valid_q;

	logic [NW-1:0] cur_q;
	logic [NW-1:0] tgt_q;
	logic [NW-1:0] src_q;
	logic [NW-1:0] dst_q;
	logic          edge_ok_q;
	logic          self_q;
	logic [DW-1:0] k_q;
	logic [DW-1:0] deg_q;
	logic [DW-1:0] sin_q;
	logic [DW-1:0] sout_q;
	logic [4:0]    node_index_q;
	logic [1:0]    status_q;
	logic          last_q;

	logic [DW-1:0] in_rd_q;
	logic [DW-1:0] out_rd_q;
	logic          in_rv_q;
	logic          out_rv_q;
	logic [1:0]    kind_rd_q;
	logic [DW-1:0] work_rd_q;
	logic [NW-1:0] stack_rd_q;
	logic [NW-1:0] edge_rd_q;

	logic          go;
	logic          hold;
	logic          emit_fire;
	logic          reject;
	logic          slot_ok;
	logic [NW-1:0] slot_n;
	logic [DW-1:0] in_deg;
	logic [DW-1:0] out_deg;
	logic [DW:0]   su;
	logic [DW:0]   tu;
	logic          seed;
	logic          push;
	logic [CW-1:0] sp_dec;
	logic          rd_in_en;
	logic          rd_out_en;
	logic          rd_kind_en;
	logic [NW-1:0] rd_in_addr;
	logic [NW-1:0] rd_out_addr;
	logic [NW-1:0] rd_kind_addr;
	logic [EW-1:0] rd_edge_addr;
	logic [EW-1:0] wr_edge_addr;

	assign slot_ok = 32'(node_slot) < 32'(MAX_NODES);
	assign slot_n  = NW'(node_slot);
	assign in_deg  = in_rv_q ? in_rd_q : '0;
	assign out_deg = out_rv_q ? out_rd_q : '0;
	assign su      = {1'b0, sin_q} + {1'b0, sout_q};
	assign tu      = {1'b0, in_deg} + {1'b0, out_deg};
	assign sp_dec  = sp_q - CW'(1);

	always_comb begin
		if (!edge_ok_q) begin
			reject = 1'b1;
		end else if (self_q) begin
			reject = (32'(su) + 32'd2) > 32'(EDGE_SLOTS);
		end else begin
			reject = ((32'(su) + 32'd1) > 32'(EDGE_SLOTS))
				|| ((32'(tu) + 32'd1) > 32'(EDGE_SLOTS));
		end
	end

	assign seed = used_q[cur_q] && (in_deg == '0) && (!pass_q || kind_rd_q == KIND_INPUT);
	assign push = (work_rd_q == DW'(1)) && used_q[tgt_q];

	always_comb begin
		unique case (ctrl.emit)
			EM_NONE:   emit_fire = 1'b0;
			EM_NODE:   emit_fire = pass_q
				&& (kind_rd_q == KIND_SHADER || kind_rd_q == KIND_OUTPUT);
			EM_REJECT: emit_fire = reject;
			EM_CYCLE:  emit_fire = !pass_q && (vis_q != ucnt_q);
			EM_DONE:   emit_fire = 1'b1;
			default:   emit_fire = 1'b0;
		endcase
	end

	assign hold = ((ctrl.act == ACT_ACCEPT) && !item_valid)
		|| (emit_fire && out_valid_q && !result_ready);
	assign go = !hold;

	assign item_ready = (ctrl.act == ACT_ACCEPT);

	assign stat.hold       = hold;
	assign stat.op_edge    = (opcode == OP_EDGE);
	assign stat.op_run     = (opcode == OP_RUN);
	assign stat.reject     = reject;
	assign stat.more_nodes = (cur_q != NW'(MAX_NODES - 1));
	assign stat.sp_zero    = (sp_q == '0);
	assign stat.k_done     = (k_q == deg_q);
	assign stat.pass_b     = pass_q;
	assign stat.mismatch   = !pass_q && (vis_q != ucnt_q);

	assign rd_in_en   = go && (ctrl.act == ACT_RD_SRC || ctrl.act == ACT_RD_DST
		|| ctrl.act == ACT_RD_SEED);
	assign rd_out_en  = go && (ctrl.act == ACT_RD_SRC || ctrl.act == ACT_RD_DST
		|| ctrl.act == ACT_RD_NODE);
	assign rd_kind_en = go && (ctrl.act == ACT_RD_SEED || ctrl.act == ACT_RD_NODE);

	always_comb begin
		rd_in_addr   = cur_q;
		rd_out_addr  = stack_rd_q;
		rd_kind_addr = stack_rd_q;
		unique case (ctrl.act)
			ACT_RD_SRC: begin
				rd_in_addr  = src_q;
				rd_out_addr = src_q;
			end
			ACT_RD_DST: begin
				rd_in_addr  = dst_q;
				rd_out_addr = dst_q;
			end
			ACT_RD_SEED: rd_kind_addr = cur_q;
			default: ;
		endcase
	end

	assign rd_edge_addr = EW'(cur_q) * EW'(EDGE_SLOTS) + EW'(EDGE_SLOTS - 1) - EW'(k_q);

	always_comb begin
		if (ctrl.act == ACT_EDGE_SRC) begin
			wr_edge_addr = EW'(src_q) * EW'(EDGE_SLOTS) + EW'(EDGE_SLOTS - 1) - EW'(sout_q);
		end else begin
			wr_edge_addr = EW'(dst_q) * EW'(EDGE_SLOTS) + EW'(in_deg);
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.act == ACT_EDGE_DST) begin
			in_mem[dst_q] <= in_deg + DW'(1);
		end
		if (rd_in_en) begin
			in_rd_q <= in_mem[rd_in_addr];
			in_rv_q <= in_vld_q[rd_in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.act == ACT_EDGE_SRC && !reject) begin
			out_mem[src_q] <= sout_q + DW'(1);
		end
		if (rd_out_en) begin
			out_rd_q <= out_mem[rd_out_addr];
			out_rv_q <= out_vld_q[rd_out_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.act == ACT_ACCEPT && opcode == OP_DECLARE && slot_ok) begin
			kind_mem[slot_n] <= node_kind;
		end
		if (rd_kind_en) begin
			kind_rd_q <= kind_mem[rd_kind_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.act == ACT_SEED) begin
			work_mem[cur_q] <= in_deg;
		end else if (go && ctrl.act == ACT_RELAX && work_rd_q != '0) begin
			work_mem[tgt_q] <= work_rd_q - DW'(1);
		end
		if (go && ctrl.act == ACT_RD_WORK) begin
			work_rd_q <= work_mem[edge_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.act == ACT_SEED && seed) begin
			stack_mem[sp_q[NW-1:0]] <= cur_q;
		end else if (go && ctrl.act == ACT_RELAX && push) begin
			stack_mem[sp_q[NW-1:0]] <= tgt_q;
		end
		if (go && ctrl.act == ACT_POP && sp_q != '0) begin
			stack_rd_q <= stack_mem[sp_dec[NW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (go && ((ctrl.act == ACT_EDGE_SRC && !reject) || ctrl.act == ACT_EDGE_DST)) begin
			edge_mem[wr_edge_addr] <= (ctrl.act == ACT_EDGE_SRC) ? dst_q : src_q;
		end
		if (go && ctrl.act == ACT_RD_EDGE) begin
			edge_rd_q <= edge_mem[rd_edge_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			in_vld_q    <= '0;
			out_vld_q   <= '0;
			sp_q        <= '0;
			ucnt_q      <= '0;
			vis_q       <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go && emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (go) begin
				unique case (ctrl.act)
					ACT_ACCEPT: begin
						if (opcode == OP_CLEAR) begin
							used_q    <= '0;
							in_vld_q  <= '0;
							out_vld_q <= '0;
						end else if (opcode == OP_DECLARE && slot_ok) begin
							used_q[slot_n]    <= 1'b1;
							in_vld_q[slot_n]  <= 1'b0;
							out_vld_q[slot_n] <= 1'b0;
						end
					end
					ACT_EDGE_SRC: begin
						if (!reject) begin
							out_vld_q[src_q] <= 1'b1;
						end
					end
					ACT_EDGE_DST: in_vld_q[dst_q] <= 1'b1;
					ACT_PASS_A:   pass_q <= 1'b0;
					ACT_PASS_B:   pass_q <= 1'b1;
					ACT_INIT: begin
						sp_q   <= '0;
						ucnt_q <= '0;
						vis_q  <= '0;
					end
					ACT_SEED: begin
						if (used_q[cur_q]) begin
							ucnt_q <= ucnt_q + CW'(1);
						end
						if (seed) begin
							sp_q <= sp_q + CW'(1);
						end
					end
					ACT_POP: begin
						if (sp_q != '0) begin
							sp_q <= sp_dec;
						end
					end
					ACT_VISIT: begin
						if (!pass_q) begin
							vis_q <= vis_q + CW'(1);
						end
					end
					ACT_RELAX: begin
						if (push) begin
							sp_q <= sp_q + CW'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			unique case (ctrl.act)
				ACT_ACCEPT: begin
					src_q     <= NW'(edge_source);
					dst_q     <= NW'(edge_target);
					edge_ok_q <= (32'(edge_source) < 32'(MAX_NODES))
						&& (32'(edge_target) < 32'(MAX_NODES));
					self_q    <= (edge_source == edge_target);
				end
				ACT_RD_DST: begin
					sin_q  <= in_deg;
					sout_q <= out_deg;
				end
				ACT_INIT:    cur_q <= '0;
				ACT_SEED:    cur_q <= cur_q + NW'(1);
				ACT_RD_NODE: cur_q <= stack_rd_q;
				ACT_VISIT: begin
					deg_q <= out_deg;
					k_q   <= '0;
				end
				ACT_RD_WORK: tgt_q <= edge_rd_q;
				ACT_RELAX:   k_q   <= k_q + DW'(1);
				default: ;
			endcase
			if (emit_fire) begin
				unique case (ctrl.emit)
					EM_NODE: begin
						node_index_q <= 5'(cur_q);
						status_q     <= ST_ORDERED;
						last_q       <= 1'b0;
					end
					EM_REJECT: begin
						node_index_q <= '0;
						status_q     <= ST_REJECT;
						last_q       <= 1'b1;
					end
					EM_CYCLE: begin
						node_index_q <= '0;
						status_q     <= ST_CYCLE;
						last_q       <= 1'b1;
					end
					default: begin
						node_index_q <= '0;
						status_q     <= ST_DONE;
						last_q       <= 1'b1;
					end
				endcase
			end
		end
	end

	assign result_valid = out_valid_q;
	assign node_index   = node_index_q;
	assign status       = status_q;
	assign last         = last_q;

endmodule

`default_nettype wire

// File: hdl/graph_topological_order_engine_unit.sv
// Clear and declare finish in the step that accepts them. Add edge reads the source and
// target degrees, then, unless rejected, writes the source and target sides. Run: two
// passes that seed, pop nodes and relax out-edges; the second is skipped on a cycle.
// Results leave via a one-deep output register; an unaccepted result stalls the next one.
// Reset clears the used marks, degree valid bits, stack count and step counter;
// the edge, kind, work and stack memories keep their contents.
`default_nettype none

module graph_topological_order_engine_unit import gtoe_pkg::*; #(
	parameter int MAX_NODES  = 32,
	parameter int EDGE_SLOTS = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	output logic       item_ready,
	input  wire  [1:0] opcode,
	input  wire  [4:0] node_slot,
	input  wire  [1:0] node_kind,
	input  wire  [4:0] edge_source,
	input  wire  [4:0] edge_target,
	output logic       result_valid,
	input  wire        result_ready,
	output logic [4:0] node_index,
	output logic [1:0] status,
	output logic       last
);

	ctrl_t ctrl;
	stat_t stat;

	gtoe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	gtoe_dp #(
		.MAX_NODES  (MAX_NODES),
		.EDGE_SLOTS (EDGE_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.opcode       (opcode),
		.node_slot    (node_slot),
		.node_kind    (node_kind),
		.edge_source  (edge_source),
		.edge_target  (edge_target),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.node_index   (node_index),
		.status       (status),
		.last         (last),
		.ctrl         (ctrl),
		.stat         (stat)
	);

endmodule

`default_nettype wire

// File: hdl/gtoe_chk.sv
// Port checker for the topological order engine and its bind.
`default_nettype none
`include "assert_macros.svh"

module gtoe_chk import gtoe_pkg::*; (
	input wire       clk,
	input wire       arst_n,
	input wire       item_valid,
	input wire       item_ready,
	input wire [1:0] opcode,
	input wire       result_valid,
	input wire       result_ready,
	input wire [4:0] node_index,
	input wire [1:0] status,
	input wire       last
);

	`CHK_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(node_index) && $stable(status) && $stable(last), "result transaction changed while stalled")
	`CHK_IMPLIES(a_last_flag, clk, arst_n, result_valid, (status == ST_ORDERED) == !last, "last flag does not match status")
	`CHK_IMPLIES(a_index_zero, clk, arst_n, result_valid && status != ST_ORDERED, node_index == 5'd0, "terminal result carries a node index")
	`CHK_NEXT(a_busy_after_long, clk, arst_n, item_valid && item_ready && (opcode == OP_RUN || opcode == OP_EDGE), !item_ready, "ready after an edge or run transaction")

endmodule

bind graph_topological_order_engine_unit gtoe_chk u_gtoe_chk (.*);

`default_nettype wire
